// File: hdl/imuma_pkg.sv
// Shared types and constants for the six-axis IMU moving-average filter.
`timescale 1ns / 1ps

package imuma_pkg;

    localparam int CHANNELS = 6;
    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;

    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNELS - 1);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Tag that travels with a channel sum through the divider.
    typedef struct packed {
        logic              vld;
        logic [CHAN_W-1:0] chan;
    } div_tag_t;

endpackage

// File: hdl/imuma_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module imuma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 48
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/imuma_div.sv
// Pipelined signed divide-by-WINDOW unit (reciprocal multiply plus one correction).
`timescale 1ns / 1ps

module imuma_div #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  imuma_pkg::div_tag_t    in_tag,
    input  logic signed [SUM_W-1:0] in_sum,
    output imuma_pkg::div_tag_t    out_tag,
    output imuma_pkg::sample_t     out_avg
);

    localparam int Q_W   = imuma_pkg::SAMPLE_W + 1;
    localparam int SHIFT = SUM_W;
    localparam logic [63:0] RECIP_WIDE = (64'd1 << SHIFT) / 64'(WINDOW);
    localparam logic [SHIFT:0] RECIP = RECIP_WIDE[SHIFT:0];
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);
    localparam int PROD_W = SUM_W + SHIFT + 1;

    imuma_pkg::div_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [SUM_W-1:0]    s1_mag_reg, s2_mag_reg, s3_mag_reg;
    logic                s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [Q_W-1:0]      s2_q_reg, s3_q_reg;
    logic [SUM_W-1:0]    s3_qw_reg;
    imuma_pkg::sample_t  s4_avg_reg;

    logic [SUM_W-1:0]    mag_next;
    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    qw_next;
    logic [SUM_W-1:0]    rem;
    logic [Q_W-1:0]      q_fix;
    logic [Q_W-1:0]      q_signed;

    assign mag_next = in_sum[SUM_W-1] ? SUM_W'(-in_sum) : SUM_W'(in_sum);
    assign prod     = PROD_W'(s1_mag_reg) * PROD_W'(RECIP);
    assign qw_next  = SUM_W'(SUM_W'(s2_q_reg) * WIN_C);
    assign rem      = s3_mag_reg - s3_qw_reg;
    assign q_fix    = (rem >= WIN_C) ? s3_q_reg + Q_W'(1) : s3_q_reg;
    assign q_signed = s3_neg_reg ? Q_W'(-q_fix) : q_fix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
        end else begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mag_reg <= mag_next;
        s1_neg_reg <= in_sum[SUM_W-1];
        s2_mag_reg <= s1_mag_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_q_reg   <= prod[SHIFT +: Q_W];
        s3_mag_reg <= s2_mag_reg;
        s3_neg_reg <= s2_neg_reg;
        s3_q_reg   <= s2_q_reg;
        s3_qw_reg  <= qw_next;
        s4_avg_reg <= imuma_pkg::sample_t'(q_signed[imuma_pkg::SAMPLE_W-1:0]);
    end

    assign out_tag = s4_tag_reg;
    assign out_avg = s4_avg_reg;

endmodule

// File: hdl/imu_six_axis_moving_average.sv
// Top level of the six-axis IMU moving-average filter with its sequencer.
`timescale 1ns / 1ps
// Usage:
//   s_* channel: one sample set (accel x/y/z, gyro x/y/z, signed 16 bit) per
//   transaction on s_valid/s_ready. m_* channel: one set of six window
//   averages per transaction on m_valid/m_ready, truncated toward zero.
//   Each channel keeps a ring of WINDOW samples in one shared RAM; all six
//   rings share one write slot.
// Timing:
//   After a transaction is taken, the sequencer writes the six samples (one
//   RAM write per cycle), walks all 6*WINDOW RAM entries through one
//   accumulator and feeds each channel sum to a 4-stage divider. m_valid
//   rises once the last channel's average has been loaded into the output
//   register. A new set is not taken until the previous one has been loaded
//   into the output register, as the single RAM read port and the shared
//   accumulator serve one set at a time. s_ready is high only while the sequencer is idle.
// Reset:
//   aresetn (synchronous, active low) zeroes the write slot and the fill
//   count. Ring entries that the fill count marks as not yet written add
//   zero, so early averages include zeros; no RAM clearing pass is needed.
// Stall:
//   A finished result waits in the output register until m_ready; the next
//   set is still taken and computed, then held until the register frees up.

module imu_six_axis_moving_average #(
    parameter int WINDOW = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  imuma_pkg::sample_t  s_accel_x,
    input  imuma_pkg::sample_t  s_accel_y,
    input  imuma_pkg::sample_t  s_accel_z,
    input  imuma_pkg::sample_t  s_gyro_x,
    input  imuma_pkg::sample_t  s_gyro_y,
    input  imuma_pkg::sample_t  s_gyro_z,
    output logic                m_valid,
    input  logic                m_ready,
    output imuma_pkg::sample_t  m_avg_accel_x,
    output imuma_pkg::sample_t  m_avg_accel_y,
    output imuma_pkg::sample_t  m_avg_accel_z,
    output imuma_pkg::sample_t  m_avg_gyro_x,
    output imuma_pkg::sample_t  m_avg_gyro_y,
    output imuma_pkg::sample_t  m_avg_gyro_z
);

    localparam int DEPTH  = imuma_pkg::CHANNELS * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int SUM_W  = imuma_pkg::SAMPLE_W + 1 + $clog2(WINDOW);
    localparam int CHAN_W = imuma_pkg::CHAN_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
    localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW);
    localparam logic [ADDR_W-1:0] ADDR_STEP = ADDR_W'(WINDOW);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WRITE = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic [CHAN_W-1:0]   chan_reg, chan_next;
    logic [SLOT_W-1:0]   rslot_reg, rslot_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic                m_valid_reg, m_valid_next;

    imuma_pkg::sample_t  smp_reg [imuma_pkg::CHANNELS];
    imuma_pkg::sample_t  res_reg [imuma_pkg::CHANNELS];
    imuma_pkg::sample_t  out_reg [imuma_pkg::CHANNELS];

    // Read pipeline flags, aligned with the registered RAM data.
    logic                rd_vld_reg, rd_live_reg, rd_first_reg, rd_last_reg;
    logic [CHAN_W-1:0]   rd_chan_reg;
    logic signed [SUM_W-1:0] acc_reg, acc_sum;

    logic                s_fire, out_load;
    logic                ram_we;
    logic [imuma_pkg::SAMPLE_W-1:0] ram_rdata;
    imuma_pkg::sample_t  rd_data;
    imuma_pkg::div_tag_t div_in_tag, div_out_tag;
    imuma_pkg::sample_t  div_avg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign ram_we   = (state_reg == ST_WRITE);

    imuma_ram #(
        .WIDTH(imuma_pkg::SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(addr_reg),
        .wdata(smp_reg[chan_reg]),
        .raddr(addr_reg),
        .rdata(ram_rdata)
    );

    assign rd_data = imuma_pkg::sample_t'(ram_rdata);

    // Restart the sum on a channel's first slot; drop never-written slots.
    assign acc_sum = (rd_first_reg ? SUM_W'(0) : acc_reg)
                   + (rd_live_reg ? SUM_W'(rd_data) : SUM_W'(0));

    assign div_in_tag.vld  = rd_vld_reg && rd_last_reg;
    assign div_in_tag.chan = rd_chan_reg;

    imuma_div #(
        .WINDOW(WINDOW),
        .SUM_W (SUM_W)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .in_tag (div_in_tag),
        .in_sum (acc_sum),
        .out_tag(div_out_tag),
        .out_avg(div_avg)
    );

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        fill_next    = fill_reg;
        chan_next    = chan_reg;
        rslot_next   = rslot_reg;
        addr_next    = addr_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_WRITE;
                    chan_next  = '0;
                    addr_next  = ADDR_W'(slot_reg);
                    slot_next  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + SLOT_W'(1);
                    if (fill_reg != FILL_MAX) begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            ST_WRITE: begin
                // Hop one ring per cycle: channel rings sit WINDOW apart.
                if (chan_reg == imuma_pkg::LAST_CHAN) begin
                    state_next = ST_READ;
                    chan_next  = '0;
                    rslot_next = '0;
                    addr_next  = '0;
                end else begin
                    chan_next = chan_reg + CHAN_W'(1);
                    addr_next = addr_reg + ADDR_STEP;
                end
            end
            ST_READ: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (rslot_reg == LAST_SLOT) begin
                    rslot_next = '0;
                    chan_next  = chan_reg + CHAN_W'(1);
                    if (chan_reg == imuma_pkg::LAST_CHAN) begin
                        state_next = ST_DRAIN;
                        chan_next  = '0;
                        addr_next  = '0;
                    end
                end else begin
                    rslot_next = rslot_reg + SLOT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (div_out_tag.vld && div_out_tag.chan == imuma_pkg::LAST_CHAN) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            fill_reg    <= '0;
            chan_reg    <= '0;
            rslot_reg   <= '0;
            addr_reg    <= '0;
            m_valid_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            fill_reg    <= fill_next;
            chan_reg    <= chan_next;
            rslot_reg   <= rslot_next;
            addr_reg    <= addr_next;
            m_valid_reg <= m_valid_next;
            rd_vld_reg  <= (state_reg == ST_READ);
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            smp_reg[0] <= s_accel_x;
            smp_reg[1] <= s_accel_y;
            smp_reg[2] <= s_accel_z;
            smp_reg[3] <= s_gyro_x;
            smp_reg[4] <= s_gyro_y;
            smp_reg[5] <= s_gyro_z;
        end
        rd_live_reg  <= (FILL_W'(rslot_reg) < fill_reg);
        rd_first_reg <= (rslot_reg == '0);
        rd_last_reg  <= (rslot_reg == LAST_SLOT);
        rd_chan_reg  <= chan_reg;
        if (rd_vld_reg) begin
            acc_reg <= acc_sum;
        end
        if (div_out_tag.vld) begin
            res_reg[div_out_tag.chan] <= div_avg;
        end
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_avg_accel_x = out_reg[0];
    assign m_avg_accel_y = out_reg[1];
    assign m_avg_accel_z = out_reg[2];
    assign m_avg_gyro_x  = out_reg[3];
    assign m_avg_gyro_y  = out_reg[4];
    assign m_avg_gyro_z  = out_reg[5];

    // Divider results only come back while a sample set is in flight.
    a_div_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        div_out_tag.vld |-> (state_reg == ST_READ || state_reg == ST_DRAIN))
        else $error("divider result outside of processing");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count above window size");

    // Slot and fill move together until the window first fills.
    a_slot_tracks_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg != FILL_MAX) |-> (FILL_W'(slot_reg) == fill_reg))
        else $error("write slot out of step with fill count");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && m_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("result dropped while output register busy");

endmodule
